@@ rtl/core/sdhh_pkg.sv @@
package sdhh_pkg;

  // APB address width: seven 32-bit registers at byte offsets 0..24
  localparam int unsigned ADDR_W = 5;

  // Command codes carried in the input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Heading wrap and turn limit, sixteenths of a degree / millivolts
  localparam logic signed [13:0] HALF_TURN  = 14'sd2880;
  localparam logic signed [13:0] FULL_TURN  = 14'sd5760;
  localparam logic signed [23:0] TURN_LIMIT = 24'sd12000;

  // Register reset values
  localparam logic [22:0] RST_TARGET_DISTANCE = 23'd0;
  localparam logic [13:0] RST_FWD_LIMIT       = 14'd12000;
  localparam logic [12:0] RST_TARGET_HEADING  = 13'd0;
  localparam logic [15:0] RST_MOVE_GAIN       = 16'd16000;
  localparam logic [15:0] RST_TURN_KP         = 16'd16000;
  localparam logic [15:0] RST_TURN_KD         = 16'd0;
  localparam logic [13:0] RST_FWD_OFFSET      = 14'd1000;

  typedef enum logic [2:0] {
    REG_TARGET_DISTANCE = 3'd0,
    REG_FWD_LIMIT       = 3'd1,
    REG_TARGET_HEADING  = 3'd2,
    REG_MOVE_GAIN       = 3'd3,
    REG_TURN_KP         = 3'd4,
    REG_TURN_KD         = 3'd5,
    REG_FWD_OFFSET      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic              cmd;
    logic signed [23:0] left_position;
    logic signed [23:0] right_position;
    logic [12:0]        heading_reading;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               done_res;
  } out_word_t;

  typedef struct packed {
    logic [22:0] target_distance;
    logic [13:0] fwd_limit;
    logic [12:0] target_heading;
    logic [15:0] move_gain;
    logic [15:0] turn_kp;
    logic [15:0] turn_kd;
    logic [13:0] fwd_offset;
  } cfg_t;

  // Error stage -> multiply stage
  typedef struct packed {
    logic               tick;
    logic               done;
    logic signed [25:0] remain;
    logic signed [12:0] err;
    logic signed [13:0] err_delta;
  } front_t;

  // Multiply stage -> output stage
  typedef struct packed {
    logic               tick;
    logic               done;
    logic signed [42:0] fwd_prod;
    logic signed [29:0] kp_prod;
    logic signed [30:0] kd_prod;
  } prod_t;

endpackage

@@ rtl/core/straight_drive_heading_hold.sv @@
// Straight-line drive with heading hold for a differential drive base.
// Input channel (in_valid_i/in_ready_o, in_word_i): one word per control
// event. cmd start latches both encoder readings as the zero point and
// clears the heading-error history; its result word is all zero. cmd tick
// carries encoder positions and gyro heading; the result word gives left
// and right drive in mV (forward +/- turn) and done_res once the averaged
// travel reaches target_distance.
// Output channel (out_valid_o/out_ready_i, out_word_o): one word per input.
// Pipeline: input reg -> error/position stage -> multiply stage -> output
// reg; a word is registered in each of them in turn.
// Throughput: one word per cycle while out_ready_i is high; each stage has
// its own valid bit and advances when the stage after it is empty or being
// drained, so a word can enter while a finished result still waits.
// Receiver stall: out_word_o holds; the stages behind fill up and then
// in_ready_o drops. Encoder offsets and heading history update as a word
// leaves the input register, so back-to-back words see each other's state.
// Reset: asynchronous, active low; pipeline empties, offsets and history
// clear, registers return to their defaults. APB registers may only be
// written while the pipeline is empty.
module straight_drive_heading_hold import sdhh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o
);

  cfg_t   cfg;
  front_t front;
  prod_t  prod;
  logic   front_valid, front_ready;
  logic   prod_valid, prod_ready;

  sdhh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // offsets, averaged position, wrapped heading error
  sdhh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg),
    .valid_o    (front_valid),
    .ready_i    (front_ready),
    .front_o    (front)
  );

  // gain products, one multiplier deep
  sdhh_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .front_i (front),
    .cfg_i   (cfg),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod)
  );

  // scaling, clamps, left/right mix and output register
  sdhh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod_valid),
    .ready_o     (prod_ready),
    .prod_i      (prod),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/core/sdhh_cfg_regs.sv @@
module sdhh_cfg_regs import sdhh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_distance <= RST_TARGET_DISTANCE;
      cfg_q.fwd_limit       <= RST_FWD_LIMIT;
      cfg_q.target_heading  <= RST_TARGET_HEADING;
      cfg_q.move_gain       <= RST_MOVE_GAIN;
      cfg_q.turn_kp         <= RST_TURN_KP;
      cfg_q.turn_kd         <= RST_TURN_KD;
      cfg_q.fwd_offset      <= RST_FWD_OFFSET;
    end else if (wr) begin
      unique case (idx)
        REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[22:0];
        REG_FWD_LIMIT:       cfg_q.fwd_limit       <= pwdata[13:0];
        REG_TARGET_HEADING:  cfg_q.target_heading  <= pwdata[12:0];
        REG_MOVE_GAIN:       cfg_q.move_gain       <= pwdata[15:0];
        REG_TURN_KP:         cfg_q.turn_kp         <= pwdata[15:0];
        REG_TURN_KD:         cfg_q.turn_kd         <= pwdata[15:0];
        REG_FWD_OFFSET:      cfg_q.fwd_offset      <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_DISTANCE: prdata = {9'd0, cfg_q.target_distance};
      REG_FWD_LIMIT:       prdata = {18'd0, cfg_q.fwd_limit};
      REG_TARGET_HEADING:  prdata = {19'd0, cfg_q.target_heading};
      REG_MOVE_GAIN:       prdata = {16'd0, cfg_q.move_gain};
      REG_TURN_KP:         prdata = {16'd0, cfg_q.turn_kp};
      REG_TURN_KD:         prdata = {16'd0, cfg_q.turn_kd};
      REG_FWD_OFFSET:      prdata = {18'd0, cfg_q.fwd_offset};
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/sdhh_front.sv @@
module sdhh_front import sdhh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  cfg_t     cfg_i,
  output logic     valid_o,
  input  logic     ready_i,
  output front_t   front_o
);

  in_word_t           in_q;
  logic               in_v_q;
  front_t             a_q, a_d;
  logic               a_v_q;
  logic signed [23:0] left_offset_q, right_offset_q;
  logic signed [12:0] last_err_q;

  logic               a_ready, in_ld, a_ld;
  logic signed [24:0] dl, dr, pos;
  logic signed [25:0] sum;
  logic signed [13:0] e_raw, e_wrap;

  assign a_ready    = ~a_v_q | ready_i;
  assign in_ready_o = ~in_v_q | a_ready;
  assign in_ld      = in_valid_i & in_ready_o;
  assign a_ld       = in_v_q & a_ready;
  assign valid_o    = a_v_q;
  assign front_o    = a_q;

  // Position relative to the start offsets, floored mean of both wheels
  assign dl  = 25'(in_q.left_position) - 25'(left_offset_q);
  assign dr  = 25'(in_q.right_position) - 25'(right_offset_q);
  assign sum = 26'(dl) + 26'(dr);
  assign pos = sum[25:1];

  assign e_raw = $signed({1'b0, cfg_i.target_heading}) -
                 $signed({1'b0, in_q.heading_reading});

  always_comb begin
    priority if (e_raw > HALF_TURN) begin
      e_wrap = e_raw - FULL_TURN;
    end else if (e_raw < -HALF_TURN) begin
      e_wrap = e_raw + FULL_TURN;
    end else begin
      e_wrap = e_raw;
    end
  end

  always_comb begin
    a_d.tick      = (in_q.cmd == CMD_TICK);
    a_d.remain    = 26'($signed({1'b0, cfg_i.target_distance})) - 26'(pos);
    a_d.done      = a_d.remain[25] | (a_d.remain == '0);
    a_d.err       = e_wrap[12:0];
    a_d.err_delta = 14'(a_d.err) - 14'(last_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      a_v_q  <= 1'b0;
    end else begin
      if (in_ld) begin
        in_v_q <= 1'b1;
      end else if (a_ld) begin
        in_v_q <= 1'b0;
      end
      if (a_ld) begin
        a_v_q <= 1'b1;
      end else if (ready_i) begin
        a_v_q <= 1'b0;
      end
    end
  end

  // Offsets and heading history advance with the word leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_offset_q  <= '0;
      right_offset_q <= '0;
      last_err_q     <= '0;
    end else if (a_ld) begin
      if (in_q.cmd == CMD_TICK) begin
        last_err_q <= a_d.err;
      end else begin
        left_offset_q  <= in_q.left_position;
        right_offset_q <= in_q.right_position;
        last_err_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ld) begin
      in_q <= in_word_i;
    end
    if (a_ld) begin
      a_q <= a_d;
    end
  end

`ifndef SYNTHESIS
  a_err_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q |-> (a_q.err >= -13'sd2880) && (a_q.err <= 13'sd2880))
    else $error("heading error outside half turn");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_ld && (in_q.cmd == CMD_START)) |=>
      (last_err_q == '0) && (left_offset_q == $past(in_q.left_position)))
    else $error("start word did not capture offsets");
`endif

endmodule

@@ rtl/core/sdhh_mult.sv @@
module sdhh_mult import sdhh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t front_i,
  input  cfg_t   cfg_i,
  output logic   valid_o,
  input  logic   ready_i,
  output prod_t  prod_o
);

  prod_t              p_q, p_d;
  logic               v_q, ld;
  logic signed [16:0] mg_s, kp_s, kd_s;

  assign ready_o = ~v_q | ready_i;
  assign ld      = valid_i & ready_o;
  assign valid_o = v_q;
  assign prod_o  = p_q;

  assign mg_s = $signed({1'b0, cfg_i.move_gain});
  assign kp_s = $signed({1'b0, cfg_i.turn_kp});
  assign kd_s = $signed({1'b0, cfg_i.turn_kd});

  always_comb begin
    p_d.tick     = front_i.tick;
    p_d.done     = front_i.done;
    p_d.fwd_prod = 43'(front_i.remain) * 43'(mg_s);
    p_d.kp_prod  = 30'(front_i.err) * 30'(kp_s);
    p_d.kd_prod  = 31'(front_i.err_delta) * 31'(kd_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= 1'b1;
    end else if (ready_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      p_q <= p_d;
    end
  end

endmodule

@@ rtl/core/sdhh_back.sv @@
module sdhh_back import sdhh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  prod_t     prod_i,
  input  cfg_t      cfg_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  out_word_t          o_q, o_d;
  logic               v_q, ld;
  logic signed [31:0] turn_sum;
  logic signed [23:0] turn_raw;
  logic signed [14:0] turn, fwd;
  logic signed [34:0] fwd_sh;
  logic signed [35:0] fwd_raw, lim;

  assign ready_o     = ~v_q | out_ready_i;
  assign ld          = valid_i & ready_o;
  assign out_valid_o = v_q;
  assign out_word_o  = o_q;

  // Q8.8 scaling: arithmetic shift gives the floor
  assign turn_sum = 32'(prod_i.kp_prod) + 32'(prod_i.kd_prod);
  assign turn_raw = turn_sum[31:8];
  assign fwd_sh   = prod_i.fwd_prod[42:8];
  assign fwd_raw  = 36'(fwd_sh) + 36'($signed({1'b0, cfg_i.fwd_offset}));
  assign lim      = 36'($signed({1'b0, cfg_i.fwd_limit}));

  always_comb begin
    priority if (turn_raw > TURN_LIMIT) begin
      turn = TURN_LIMIT[14:0];
    end else if (turn_raw < -TURN_LIMIT) begin
      turn = 15'(-TURN_LIMIT);
    end else begin
      turn = turn_raw[14:0];
    end
  end

  always_comb begin
    priority if (fwd_raw > lim) begin
      fwd = lim[14:0];
    end else if (fwd_raw < -lim) begin
      fwd = 15'(-lim);
    end else begin
      fwd = fwd_raw[14:0];
    end
  end

  always_comb begin
    if (prod_i.tick) begin
      o_d.left_drive  = 16'(fwd) + 16'(turn);
      o_d.right_drive = 16'(fwd) - 16'(turn);
      o_d.done_res    = prod_i.done;
    end else begin
      o_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= 1'b1;
    end else if (out_ready_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      o_q <= o_d;
    end
  end

`ifndef SYNTHESIS
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && !prod_i.tick) |=>
      (o_q.left_drive == '0) && (o_q.right_drive == '0) && !o_q.done_res)
    else $error("start word produced nonzero drive");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (o_q.left_drive >= -16'sd28383) && (o_q.left_drive <= 16'sd28383) &&
            (o_q.right_drive >= -16'sd28383) && (o_q.right_drive <= 16'sd28383))
    else $error("drive beyond forward plus turn limits");
`endif

endmodule
